FILE: src/assert_macros.svh
// Assertion macros for the address range symbol table RTL.
// Checks are compiled in by default and drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Property must never hold outside reset
`define AST_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
		else $error("forbidden condition seen");
`else
`define AST_HOLDS(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

FILE: src/arsym_pkg.sv
// Shared types and constants for the address range symbol table.
// No dependencies; imported by arsym_cell and address_range_symbol_table.
`timescale 1ns / 1ps
package arsym_pkg;

	localparam int ENTRIES  = 64;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int ADDR_W   = 32;
	localparam int SIZE_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int FUNC_W   = 2;
	localparam int STAT_W   = 2;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_FIND   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Request token handed from cell to cell
	typedef struct packed {
		logic                vld;
		func_t               func;
		logic [ADDR_W-1:0]   address;
		logic                dup;
		logic                free_hit;
		logic [IDX_W-1:0]    free_idx;
		logic                best_hit;
		logic [ADDR_W-1:0]   best_start;
		logic [SIZE_W-1:0]   best_len;
		logic [HANDLE_W-1:0] best_handle;
	} pkt_t;

	// Broadcast write / clear from the controller to all cells
	typedef struct packed {
		logic                en;
		logic                clear;
		logic [IDX_W-1:0]    idx;
		logic [ADDR_W-1:0]   start;
		logic [SIZE_W-1:0]   len;
		logic [HANDLE_W-1:0] handle;
	} wr_t;

endpackage

FILE: src/arsym_cell.sv
// One table slot plus one stage of the request token chain.
// Depends on arsym_pkg.
`timescale 1ns / 1ps
module arsym_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [arsym_pkg::IDX_W-1:0] cell_idx,
	input  arsym_pkg::pkt_t             pin,
	input  arsym_pkg::wr_t              wr,
	output arsym_pkg::pkt_t             pout
);
	import arsym_pkg::*;

	logic                valid_q;
	logic [ADDR_W-1:0]   start_q;
	logic [SIZE_W-1:0]   len_q;
	logic [HANDLE_W-1:0] handle_q;
	pkt_t                pkt_q;
	pkt_t                pkt_nxt;
	logic                start_hit;
	logic                wr_hit;
	logic                rm_hit;

	assign start_hit = valid_q && (start_q == pin.address);
	assign wr_hit    = wr.en && (wr.idx == cell_idx);
	assign rm_hit    = pin.vld && (pin.func == FN_REMOVE) && start_hit;

	// Token update as it passes this slot
	always_comb begin
		pkt_nxt = pin;
		if (pin.vld) begin
			unique case (pin.func)
				FN_ADD: begin
					if (start_hit)
						pkt_nxt.dup = 1'b1;
					if (!valid_q && !pin.free_hit) begin
						pkt_nxt.free_hit = 1'b1;
						pkt_nxt.free_idx = cell_idx;
					end
				end
				FN_FIND: begin
					if (valid_q && (start_q <= pin.address) &&
					    (!pin.best_hit || (start_q > pin.best_start))) begin
						pkt_nxt.best_hit    = 1'b1;
						pkt_nxt.best_start  = start_q;
						pkt_nxt.best_len    = len_q;
						pkt_nxt.best_handle = handle_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= pkt_nxt;
		end
	end

	// Slot valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.clear || rm_hit) begin
			valid_q <= 1'b0;
		end else if (wr_hit) begin
			valid_q <= 1'b1;
		end
	end

	// Slot payload
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			start_q  <= wr.start;
			len_q    <= wr.len;
			handle_q <= wr.handle;
		end
	end

	assign pout = pkt_q;

endmodule

FILE: src/address_range_symbol_table.sv
// One request is in flight at a time: a new request is taken only once the controller
// is idle again. The request token walks the row of slot cells one cell per cycle,
// then the controller settles the result.
// A new request is taken while a finished result waits on the output register.
// Reset (arst_n, async, active low) empties the table at once; no clearing pass.
// Top level of the address range symbol table; depends on arsym_pkg, arsym_cell.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module address_range_symbol_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// address[31:0], region_size[63:32], symbol_handle[79:64]
	input  logic [arsym_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [arsym_pkg::FUNC_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// found_handle[15:0], found_start[47:16]
	output logic [arsym_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [arsym_pkg::STAT_W-1:0]     m_tuser
);
	import arsym_pkg::*;

	state_t              state_q, state_nxt;
	pkt_t                chain [ENTRIES+1];
	logic [ENTRIES-1:0]  chain_vld;
	pkt_t                end_q;
	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] handle_q;
	wr_t                 wr;
	logic                in_acc;
	logic                out_free;
	logic                finish;
	logic                find_hit;
	logic [ADDR_W-1:0]   offset;
	status_t             stat_nxt;
	logic [HANDLE_W-1:0] fh_nxt;
	logic [ADDR_W-1:0]   fs_nxt;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Token launched into the first cell
	always_comb begin
		chain[0]             = '0;
		chain[0].vld         = in_acc;
		chain[0].func        = func_t'(s_tuser);
		chain[0].address     = s_tdata[ADDR_W-1:0];
	end

	// Row of slot cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		arsym_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.pin      (chain[i]),
			.wr       (wr),
			.pout     (chain[i+1])
		);
		assign chain_vld[i] = chain[i+1].vld;
	end

	// Add operands wait here while the token walks
	always_ff @(posedge clk) begin
		if (in_acc) begin
			size_q   <= s_tdata[ADDR_W +: SIZE_W];
			handle_q <= s_tdata[ADDR_W+SIZE_W +: HANDLE_W];
		end
		if (chain[ENTRIES].vld)
			end_q <= chain[ENTRIES];
	end

	// Result from the token that left the row
	assign offset   = end_q.address - end_q.best_start;
	assign find_hit = end_q.best_hit && (offset < end_q.best_len);

	always_comb begin
		stat_nxt = ST_OK;
		fh_nxt   = '0;
		fs_nxt   = '0;
		unique case (end_q.func)
			FN_ADD: begin
				if (end_q.dup)
					stat_nxt = ST_DUP;
				else if (!end_q.free_hit)
					stat_nxt = ST_FULL;
			end
			FN_FIND: begin
				if (find_hit) begin
					fh_nxt = end_q.best_handle;
					fs_nxt = end_q.best_start;
				end else begin
					stat_nxt = ST_NOTFOUND;
				end
			end
			default: ;
		endcase
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (chain[ENTRIES].vld)
					state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					finish    = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Broadcast write for add, clear for clear-all
	always_comb begin
		wr        = '0;
		wr.en     = finish && (end_q.func == FN_ADD) && !end_q.dup && end_q.free_hit;
		wr.clear  = finish && (end_q.func == FN_CLEAR);
		wr.idx    = end_q.free_idx;
		wr.start  = end_q.address;
		wr.len    = size_q;
		wr.handle = handle_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (finish)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {fs_nxt, fh_nxt};
			m_tuser_q <= stat_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// At most one token in the row at any time
	`AST_HOLDS(a_one_token, clk, arst_n, $countones(chain_vld) <= 1)
	// Token leaves the row only while the controller waits for it
	`AST_HOLDS(a_exit_in_scan, clk, arst_n, chain[ENTRIES].vld |-> state_q == S_SCAN)
	// Slot writes come only from a successful add
	`AST_NEVER(a_wr_not_add, clk, arst_n, wr.en && (end_q.func != FN_ADD || end_q.dup))
	// No new request while a token is still walking
	`AST_NEVER(a_accept_busy, clk, arst_n, in_acc && (chain_vld != '0))

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the address range symbol table.
// A table predictor checks status, handle and start of every result in order.
// Depends on arsym_pkg and address_range_symbol_table.
`timescale 1ns / 1ps
module tb;
	import arsym_pkg::*;

	localparam int REQ_TARGET  = 1700;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_SLACK = ENTRIES + 10;

	typedef struct {
		func_t               func;
		logic [ADDR_W-1:0]   addr;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
	} request_t;

	typedef struct {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [ADDR_W-1:0]   start;
	} lookup_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = FN_ADD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	// Stimulus and scoreboard storage
	request_t       request_queue[$];
	lookup_result_t pending_results[$];
	logic [ADDR_W-1:0] start_pool[$];

	// Predicted table contents
	logic                tbl_valid[ENTRIES];
	logic [ADDR_W-1:0]   tbl_start[ENTRIES];
	logic [SIZE_W-1:0]   tbl_len[ENTRIES];
	logic [HANDLE_W-1:0] tbl_handle[ENTRIES];

	logic           in_fire = 1'b0;
	int             n_fail = 0;
	int             idle_cycles = 0;
	int             burst_left = 1;
	int             gap_left = 0;
	int             stall_left = 0;
	int             stall_mode = 0;
	int             mode_left = 0;
	request_t       cur_req;
	request_t       seen_req;
	lookup_result_t want;

	address_range_symbol_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Apply one request to the predicted table and return its result
	function automatic lookup_result_t apply_to_table(request_t rq);
		lookup_result_t r;
		int slot;
		int best;
		logic [ADDR_W-1:0] offset;
		r.status = ST_OK;
		r.handle = '0;
		r.start  = '0;
		slot = -1;
		best = -1;
		case (rq.func)
			FN_ADD: begin
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_start[i] == rq.addr)
						slot = i;
				if (slot >= 0) begin
					r.status = ST_DUP;
				end else begin
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!tbl_valid[i])
							slot = i;
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						tbl_valid[slot]  = 1'b1;
						tbl_start[slot]  = rq.addr;
						tbl_len[slot]    = rq.size;
						tbl_handle[slot] = rq.handle;
					end
				end
			end
			FN_REMOVE: begin
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_start[i] == rq.addr)
						tbl_valid[i] = 1'b0;
			end
			FN_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					tbl_valid[i] = 1'b0;
			end
			default: begin
				// greatest valid start at or below the probe
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_start[i] <= rq.addr &&
							(best < 0 || tbl_start[i] > tbl_start[best]))
						best = i;
				// wrapped 32-bit offset avoids forming the 33-bit end
				if (best >= 0)
					offset = rq.addr - tbl_start[best];
				if (best >= 0 && offset < tbl_len[best]) begin
					r.handle = tbl_handle[best];
					r.start  = tbl_start[best];
				end else begin
					r.status = ST_NOTFOUND;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void push_req(func_t f, logic [ADDR_W-1:0] a,
			logic [SIZE_W-1:0] s, logic [HANDLE_W-1:0] h);
		request_t rq;
		rq.func   = f;
		rq.addr   = a;
		rq.size   = s;
		rq.handle = h;
		request_queue.push_back(rq);
	endfunction

	// Mostly small sizes, with zero, full and random sizes mixed in
	function automatic logic [SIZE_W-1:0] rand_size(logic [ADDR_W-1:0] span);
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(1, span / 16 + 1);
		endcase
	endfunction

	// One random request inside the current address cluster
	function automatic void gen_op(int add_weight, logic [ADDR_W-1:0] base,
			logic [ADDR_W-1:0] span);
		int pick;
		int idx;
		func_t f;
		logic [ADDR_W-1:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// noise: anything but a clear, fully random fields
			f = func_t'($urandom_range(0, 3));
			if (f == FN_CLEAR)
				f = FN_FIND;
			push_req(f, $urandom, $urandom, HANDLE_W'($urandom));
		end else if (pick < 8 + add_weight) begin
			if (start_pool.size() > 0 && $urandom_range(0, 9) == 0)
				a = start_pool[$urandom_range(0, start_pool.size() - 1)];
			else
				a = base + $urandom_range(0, span);
			start_pool.push_back(a);
			push_req(FN_ADD, a, rand_size(span), HANDLE_W'($urandom));
		end else if (pick < 8 + add_weight + 15) begin
			if (start_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
				idx = $urandom_range(0, start_pool.size() - 1);
				a = start_pool[idx];
				start_pool.delete(idx);
			end else begin
				a = base + $urandom_range(0, span);
			end
			push_req(FN_REMOVE, a, $urandom, HANDLE_W'($urandom));
		end else begin
			if (start_pool.size() > 0 && $urandom_range(0, 6) != 0) begin
				a = start_pool[$urandom_range(0, start_pool.size() - 1)];
				if ($urandom_range(0, 7) == 0)
					a = a - 1;
				else
					a = a + $urandom_range(0, span / 8 + 1);
			end else begin
				a = base + $urandom_range(0, span);
			end
			push_req(FN_FIND, a, $urandom, HANDLE_W'($urandom));
		end
	endfunction

	// Driver: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (gap_left > 0 || request_queue.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				cur_req = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {cur_req.handle, cur_req.size, cur_req.addr};
				s_tuser  <= cur_req.func;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Receiver: stall pattern switches between modes every so often
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 3000);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				case (stall_mode)
					1: if ($urandom_range(0, 1) == 1) stall_left = $urandom_range(1, 3);
					2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(20, 150);
					3: stall_left = $urandom_range(0, 70);
					default: ;
				endcase
			end
		end
	end

	// Monitor: check results, predict accepted requests, watch for hangs
	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing outstanding");
					n_fail++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						n_fail++;
					end
					if (m_tdata[15:0] !== want.handle) begin
						$error("found_handle: expected %0h, got %0h", want.handle,
							m_tdata[15:0]);
						n_fail++;
					end
					if (m_tdata[47:16] !== want.start) begin
						$error("found_start: expected %0h, got %0h", want.start,
							m_tdata[47:16]);
						n_fail++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				seen_req.func   = func_t'(s_tuser);
				seen_req.addr   = s_tdata[31:0];
				seen_req.size   = s_tdata[63:32];
				seen_req.handle = s_tdata[79:64];
				pending_results.push_back(apply_to_table(seen_req));
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] span;
		int kind;
		int n;
		for (int i = 0; i < ENTRIES; i++)
			tbl_valid[i] = 1'b0;

		// Directed: empty table, exact starts, top of space, zero size
		push_req(FN_FIND,   32'h0000_0000, 32'h0,         16'h0);
		push_req(FN_REMOVE, 32'hFFFF_FFFF, 32'h0,         16'h0);
		push_req(FN_ADD,    32'h0000_0000, 32'h10,        16'hFFFF);
		push_req(FN_ADD,    32'h0000_0000, 32'h20,        16'h1111);
		push_req(FN_FIND,   32'h0000_0000, 32'h0,         16'h0);
		push_req(FN_FIND,   32'h0000_000F, 32'h0,         16'h0);
		push_req(FN_FIND,   32'h0000_0010, 32'h0,         16'h0);
		push_req(FN_ADD,    32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'h0000);
		push_req(FN_FIND,   32'hFFFF_FFFF, 32'h0,         16'h0);
		push_req(FN_ADD,    32'h0000_0100, 32'h0,         16'h1234);
		push_req(FN_FIND,   32'h0000_0100, 32'h0,         16'h0);
		push_req(FN_ADD,    32'h0000_0080, 32'hFFFF_FFFF, 16'hA5A5);
		// greatest start is the zero-size region, so no match
		push_req(FN_FIND,   32'h0000_0100, 32'h0,         16'h0);
		push_req(FN_FIND,   32'h0000_00FF, 32'h0,         16'h0);
		push_req(FN_REMOVE, 32'h0000_0080, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(FN_FIND,   32'h0000_00FF, 32'h0,         16'h0);
		push_req(FN_REMOVE, 32'h0000_0080, 32'h0,         16'h0);
		push_req(FN_ADD,    32'h0000_0080, 32'h40,        16'h5A5A);
		push_req(FN_FIND,   32'h0000_00BF, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(FN_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(FN_FIND,   32'hFFFF_FFFF, 32'h0,         16'h0);
		push_req(FN_ADD,    32'h7FFF_FFFF, 32'h1,         16'h8000);
		push_req(FN_FIND,   32'h7FFF_FFFF, 32'h0,         16'h0);
		push_req(FN_FIND,   32'h8000_0000, 32'h0,         16'h0);

		// Random: episodes of clustered regions, some filling the table
		base = $urandom;
		span = 32'hFFF;
		while (request_queue.size() < REQ_TARGET) begin
			kind = $urandom_range(0, 9);
			if ($urandom_range(0, 1) == 0)
				base = $urandom;
			case ($urandom_range(0, 3))
				0: span = 32'hFF;
				1: span = 32'hFFF;
				2: span = 32'hFFFF;
				default: span = $urandom;
			endcase
			if (kind <= 2) begin
				push_req(FN_CLEAR, $urandom, $urandom, HANDLE_W'($urandom));
				start_pool.delete();
			end
			if (kind <= 1) begin
				// overfill, then work on a full table
				n = $urandom_range(62, 80);
				repeat (n) gen_op(92, base, span);
				repeat (30) gen_op(30, base, span);
			end else begin
				n = $urandom_range(30, 120);
				repeat (n) gen_op(35, base, span);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);

		if (n_fail == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
